// File: hdl/tos_pkg.sv
// tos_pkg: shared widths, op codes, register indexes and helper types
// for the two-register top-of-stack core
// depends on: nothing
`timescale 1ns / 1ps

package tos_pkg;

  // word, pointer and page geometry
  localparam int WORD_W     = 48;
  localparam int PTR_W      = 12;
  localparam int PAGE_SHIFT = 6;
  localparam int PAGE_W     = PTR_W - PAGE_SHIFT;

  // stack memory depth, a power of two; the pointer is taken modulo it
  localparam int MEM_WORDS = 4096;
  localparam int MEM_AW    = $clog2(MEM_WORDS);

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = PAGE_W;
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_PAGE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_STATE = 1'd1;
  localparam logic [PAGE_W-1:0]    LIMIT_RESET      = '1;

  // op codes
  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_LOAD     = 3'd0;
  localparam logic [OP_W-1:0] OP_FILL_AB  = 3'd1;
  localparam logic [OP_W-1:0] OP_FILL_A   = 3'd2;
  localparam logic [OP_W-1:0] OP_FILL_B   = 3'd3;
  localparam logic [OP_W-1:0] OP_EMPTY_AB = 3'd4;
  localparam logic [OP_W-1:0] OP_EMPTY_A  = 3'd5;
  localparam logic [OP_W-1:0] OP_EMPTY_B  = 3'd6;
  localparam logic [OP_W-1:0] OP_EXCHANGE = 3'd7;

  // pointer unit result
  typedef struct packed {
    logic [PTR_W-1:0] ptr;
    logic             blocked;
  } ptr_res_t;

  // memory word index of a stack pointer, pointer modulo the depth
  function automatic logic [MEM_AW-1:0] mem_index(input logic [PTR_W-1:0] p);
    logic [MEM_AW+PTR_W-1:0] wide;
    wide = {{MEM_AW{1'b0}}, p};
    return wide[MEM_AW-1:0];
  endfunction

endpackage

// File: hdl/two_register_top_of_stack_core.sv
// two_register_top_of_stack_core: A/B top-of-stack registers over a
// single-port stack memory, stepped by a small sequencer
// depends on: tos_pkg, tos_ptr_unit
`timescale 1ns / 1ps

// Usage:
//   Input channel in_*: one beat carries an op and the load fields. A beat
//   is taken when in_valid is high and in_stall is low.
//   Result channel out_*: one beat per op with A, B, their full flags, the
//   stack pointer and the sticky overflow flag as they stand after the op.
//   Config port cfg_*: cfg_we writes the limit page (index 0) or the
//   normal-state enable (index 1); write only while no op is in flight.
//   Sequencing: a load shows its result the cycle after it is taken. Other ops
//   step one action at a time through the single memory port: a push or a
//   register move passes the exec state, a pop the exec and pop states
//   (registered read); a final exec pass finishes and the result state follows.
//   One op is in flight at a time; the next beat is taken the cycle after the
//   result beat leaves.
//   Reset: A, B, pointer, full and overflow flags clear, then a clearing
//   pass zeroes all MEM_WORDS (4096) memory words, one per cycle, with in_stall high.
//   Stall: while out_stall is high the result holds and in_stall stays high.

module two_register_top_of_stack_core (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [tos_pkg::OP_W-1:0]       in_op,
  input  logic [tos_pkg::WORD_W-1:0]     in_new_a,
  input  logic [tos_pkg::WORD_W-1:0]     in_new_b,
  input  logic                           in_new_a_full,
  input  logic                           in_new_b_full,
  input  logic [tos_pkg::PTR_W-1:0]      in_new_stack_ptr,
  input  logic                           in_clear_overflow,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [tos_pkg::WORD_W-1:0]     out_a_value,
  output logic [tos_pkg::WORD_W-1:0]     out_b_value,
  output logic                           out_a_occupied,
  output logic                           out_b_occupied,
  output logic [tos_pkg::PTR_W-1:0]      out_stack_ptr,
  output logic                           out_overflow,
  // configuration
  input  logic                           cfg_we,
  input  logic [tos_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tos_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // sequencer states
  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EXEC  = 3'd2;
  localparam logic [2:0] ST_POP   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  // single actions chosen in the exec state
  localparam logic [2:0] ACT_DONE    = 3'd0;
  localparam logic [2:0] ACT_POP_A   = 3'd1;
  localparam logic [2:0] ACT_POP_B   = 3'd2;
  localparam logic [2:0] ACT_PUSH_A  = 3'd3;
  localparam logic [2:0] ACT_PUSH_B  = 3'd4;
  localparam logic [2:0] ACT_MOVE_BA = 3'd5;
  localparam logic [2:0] ACT_MOVE_AB = 3'd6;
  localparam logic [2:0] ACT_SWAP    = 3'd7;

  logic [2:0]                       state_r, state_nxt;
  logic [tos_pkg::OP_W-1:0]         op_r, op_nxt;
  logic                             first_r, first_nxt;
  logic                             pop_to_a_r, pop_to_a_nxt;
  logic [tos_pkg::WORD_W-1:0]       a_r, a_nxt;
  logic [tos_pkg::WORD_W-1:0]       b_r, b_nxt;
  logic                             afull_r, afull_nxt;
  logic                             bfull_r, bfull_nxt;
  logic [tos_pkg::PTR_W-1:0]        sp_r, sp_nxt;
  logic                             ovf_r, ovf_nxt;
  logic [tos_pkg::MEM_AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [tos_pkg::PAGE_W-1:0]       limit_r;
  logic                             normal_r;

  // stack memory, single port with registered read
  logic [tos_pkg::WORD_W-1:0]       mem [tos_pkg::MEM_WORDS];
  logic [tos_pkg::WORD_W-1:0]       rd_data_r;
  logic                             mem_we;
  logic [tos_pkg::MEM_AW-1:0]       mem_addr;
  logic [tos_pkg::WORD_W-1:0]       mem_wdata;

  logic [2:0]                       act;
  tos_pkg::ptr_res_t                ptr_res;

  // shared pointer step: down while popping, up otherwise
  tos_ptr_unit u_ptr (
    .sp           (sp_r),
    .dec          (state_r == ST_POP),
    .limit_page   (limit_r),
    .normal_state (normal_r),
    .res          (ptr_res)
  );

  // next action from the op and the current full flags
  always_comb begin
    act = ACT_DONE;
    case (op_r)
      tos_pkg::OP_FILL_AB: begin
        if (afull_r && !bfull_r)      act = ACT_POP_B;
        else if (!afull_r && bfull_r) act = ACT_MOVE_BA;
        else if (!afull_r)            act = ACT_POP_A;
      end
      tos_pkg::OP_FILL_A: begin
        if (!afull_r) act = bfull_r ? ACT_MOVE_BA : ACT_POP_A;
      end
      tos_pkg::OP_FILL_B: begin
        if (!bfull_r) act = ACT_POP_B;
      end
      tos_pkg::OP_EMPTY_AB: begin
        if (bfull_r)      act = ACT_PUSH_B;
        else if (afull_r) act = ACT_PUSH_A;
      end
      tos_pkg::OP_EMPTY_A: begin
        if (afull_r) act = bfull_r ? ACT_PUSH_B : ACT_MOVE_AB;
      end
      tos_pkg::OP_EMPTY_B: begin
        if (bfull_r) act = ACT_PUSH_B;
      end
      tos_pkg::OP_EXCHANGE: begin
        if (afull_r && bfull_r)       act = first_r ? ACT_SWAP : ACT_DONE;
        else if (afull_r)             act = ACT_MOVE_AB;
        else if (bfull_r)             act = ACT_POP_A;
        else                          act = ACT_POP_B;
      end
      default: act = ACT_DONE;
    endcase
  end

  // sequencer and datapath next values
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    first_nxt    = first_r;
    pop_to_a_nxt = pop_to_a_r;
    a_nxt        = a_r;
    b_nxt        = b_r;
    afull_nxt    = afull_r;
    bfull_nxt    = bfull_r;
    sp_nxt       = sp_r;
    ovf_nxt      = ovf_r;
    clr_cnt_nxt  = clr_cnt_r;
    mem_we       = 1'b0;
    mem_addr     = tos_pkg::mem_index(sp_r);
    mem_wdata    = '0;
    case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        mem_addr    = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + tos_pkg::MEM_AW'(1);
        if (clr_cnt_r == tos_pkg::MEM_AW'(tos_pkg::MEM_WORDS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          if (in_op == tos_pkg::OP_LOAD) begin
            a_nxt     = in_new_a;
            b_nxt     = in_new_b;
            afull_nxt = in_new_a_full;
            bfull_nxt = in_new_b_full;
            sp_nxt    = in_new_stack_ptr;
            if (in_clear_overflow) ovf_nxt = 1'b0;
            state_nxt = ST_OUT;
          end else begin
            op_nxt    = in_op;
            first_nxt = 1'b1;
            state_nxt = ST_EXEC;
          end
        end
      end
      ST_EXEC: begin
        first_nxt = 1'b0;
        case (act)
          ACT_POP_A, ACT_POP_B: begin
            // read issued at the pointer, data lands next cycle
            pop_to_a_nxt = (act == ACT_POP_A);
            state_nxt    = ST_POP;
          end
          ACT_PUSH_A, ACT_PUSH_B: begin
            // pre-increment push unless the limit page blocks it
            if (ptr_res.blocked) begin
              ovf_nxt = 1'b1;
            end else begin
              sp_nxt    = ptr_res.ptr;
              mem_we    = 1'b1;
              mem_addr  = tos_pkg::mem_index(ptr_res.ptr);
              mem_wdata = (act == ACT_PUSH_A) ? a_r : b_r;
            end
            if (act == ACT_PUSH_A) afull_nxt = 1'b0;
            else                   bfull_nxt = 1'b0;
          end
          ACT_MOVE_BA: begin
            a_nxt     = b_r;
            afull_nxt = 1'b1;
            bfull_nxt = 1'b0;
          end
          ACT_MOVE_AB: begin
            b_nxt     = a_r;
            bfull_nxt = 1'b1;
            afull_nxt = 1'b0;
          end
          ACT_SWAP: begin
            a_nxt = b_r;
            b_nxt = a_r;
          end
          default: state_nxt = ST_OUT;
        endcase
      end
      ST_POP: begin
        // post-decrement pop
        sp_nxt = ptr_res.ptr;
        if (pop_to_a_r) begin
          a_nxt     = rd_data_r;
          afull_nxt = 1'b1;
        end else begin
          b_nxt     = rd_data_r;
          bfull_nxt = 1'b1;
        end
        state_nxt = ST_EXEC;
      end
      ST_OUT: begin
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
      afull_r   <= 1'b0;
      bfull_r   <= 1'b0;
      sp_r      <= '0;
      ovf_r     <= 1'b0;
      a_r       <= '0;
      b_r       <= '0;
      first_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      afull_r   <= afull_nxt;
      bfull_r   <= bfull_nxt;
      sp_r      <= sp_nxt;
      ovf_r     <= ovf_nxt;
      a_r       <= a_nxt;
      b_r       <= b_nxt;
      first_r   <= first_nxt;
    end
  end

  // op holding registers
  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    pop_to_a_r <= pop_to_a_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r  <= tos_pkg::LIMIT_RESET;
      normal_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        tos_pkg::CFG_LIMIT_PAGE:   limit_r  <= cfg_wdata;
        tos_pkg::CFG_NORMAL_STATE: normal_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // stack memory port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rd_data_r <= mem[mem_addr];
  end

  // channel outputs
  assign in_stall       = (state_r != ST_IDLE);
  assign out_valid      = (state_r == ST_OUT);
  assign out_a_value    = a_r;
  assign out_b_value    = b_r;
  assign out_a_occupied = afull_r;
  assign out_b_occupied = bfull_r;
  assign out_stack_ptr  = sp_r;
  assign out_overflow   = ovf_r;

endmodule

// File: hdl/tos_ptr_unit.sv
// tos_ptr_unit: shared stack pointer step (+1 / -1) and limit page compare
// depends on: tos_pkg
`timescale 1ns / 1ps

module tos_ptr_unit (
  input  logic [tos_pkg::PTR_W-1:0]  sp,
  input  logic                       dec,
  input  logic [tos_pkg::PAGE_W-1:0] limit_page,
  input  logic                       normal_state,
  output tos_pkg::ptr_res_t          res
);

  always_comb begin
    // step the pointer, wrapping in both directions
    if (dec) begin
      res.ptr = sp - tos_pkg::PTR_W'(1);
    end else begin
      res.ptr = sp + tos_pkg::PTR_W'(1);
    end
    // push is blocked when normal state is on and the pointer sits on the limit page
    res.blocked = normal_state &&
                  (sp[tos_pkg::PTR_W-1:tos_pkg::PAGE_SHIFT] == limit_page);
  end

endmodule

// File: hdl/tos_checker.sv
// tos_checker: port-level assertions for the top-of-stack core, bound to it
// depends on: tos_pkg, two_register_top_of_stack_core
`timescale 1ns / 1ps

module tos_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic [tos_pkg::OP_W-1:0]     in_op,
  input logic [tos_pkg::WORD_W-1:0]   in_new_a,
  input logic [tos_pkg::PTR_W-1:0]    in_new_stack_ptr,
  input logic                         in_clear_overflow,
  input logic                         out_valid,
  input logic [tos_pkg::WORD_W-1:0]   out_a_value,
  input logic [tos_pkg::PTR_W-1:0]    out_stack_ptr,
  input logic                         out_overflow
);

  logic in_beat;
  logic load_clear_beat;

  assign in_beat         = in_valid && !in_stall;
  assign load_clear_beat = in_beat && (in_op == tos_pkg::OP_LOAD) && in_clear_overflow;

  // a result is never on offer while a new beat is taken
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |-> !out_valid)
    else $error("result offered while input beat taken");

  // held result keeps the input side closed
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // load shows its fields the next cycle
  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && in_op == tos_pkg::OP_LOAD) |=>
      (out_valid && out_stack_ptr == $past(in_new_stack_ptr) &&
       out_a_value == $past(in_new_a)))
    else $error("load result mismatch");

  // overflow is sticky until a clearing load
  a_ovf_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(out_overflow)) |-> $past(load_clear_beat))
    else $error("overflow dropped without clearing load");

endmodule

bind two_register_top_of_stack_core tos_checker u_tos_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_op             (in_op),
  .in_new_a          (in_new_a),
  .in_new_stack_ptr  (in_new_stack_ptr),
  .in_clear_overflow (in_clear_overflow),
  .out_valid         (out_valid),
  .out_a_value       (out_a_value),
  .out_stack_ptr     (out_stack_ptr),
  .out_overflow      (out_overflow)
);
